// ===== design/gbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants for the grid distance map
// Grid geometry, field widths, request and register codes, sequencer states.
// ----------------------------------------------------------------------------
package gbfs_pkg;

   localparam int GRID_W  = 32;
   localparam int GRID_H  = 32;
   localparam int CELLS   = GRID_W * GRID_H;
   localparam int XW      = $clog2(GRID_W);
   localparam int YW      = $clog2(GRID_H);
   localparam int IDX_W   = $clog2(CELLS);
   localparam int PTR_W   = IDX_W + 1;
   localparam int COORD_W = 5;
   localparam int DIST_W  = 10;
   localparam int COUNT_W = 11;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 5;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_FLOOD  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [CSR_IW-1:0] CSR_PORTAL_EN = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_PORTAL_AX = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_PORTAL_AY = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_PORTAL_BX = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_PORTAL_BY = 3'd4;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_WR, S_RDA, S_RDW, S_CLR, S_SEED, S_POP, S_POPW,
      S_CURD, S_NBR, S_NBE, S_PA, S_PB, S_PC, S_FIN, S_DONE
   } state_type;

   function automatic logic in_grid(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
      return (int'(x) < GRID_W) && (int'(y) < GRID_H);
   endfunction

   function automatic logic [IDX_W-1:0] cell_index(input logic [XW-1:0] x,
                                                   input logic [YW-1:0] y);
      return IDX_W'(y) * IDX_W'(GRID_W) + IDX_W'(x);
   endfunction

endpackage

// ===== design/gbfs_if.sv =====
// ----------------------------------------------------------------------------
// gbfs channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface gbfs_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [gbfs_pkg::COORD_W-1:0] cell_x;
   logic [gbfs_pkg::COORD_W-1:0] cell_y;
   logic                         blocked;
   modport source (output valid, req_type, cell_x, cell_y, blocked, input ready);
   modport sink   (input valid, req_type, cell_x, cell_y, blocked, output ready);
endinterface

interface gbfs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         reachable;
   logic [gbfs_pkg::DIST_W-1:0]  distance;
   logic [gbfs_pkg::COUNT_W-1:0] reached_count;
   modport source (output valid, reachable, distance, reached_count, input ready);
   modport sink   (input valid, reachable, distance, reached_count, output ready);
endinterface

interface gbfs_csr_if;
   logic                        valid;
   logic                        ready;
   logic [gbfs_pkg::CSR_IW-1:0] index;
   logic [gbfs_pkg::CSR_DW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/grid_bfs_distance_map_top.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_distance_map_top: wavefront distance map over a cell grid
// Wall bits, distances, visited marks and a frontier queue in block memories,
// walked by one sequencer with a single shared read port per memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per beat: write a wall bit, flood from a cell,
//   or read one cell. rsp_ch returns exactly one result per request. csr_ch
//   writes the portal registers; it is always ready.
//   A write passes S_WR, a read S_RDA and S_RDW, an unknown request none;
//   each then ends in S_DONE, and the block is ready again in the cycle the
//   result appears. A flood clears the visited marks in a sweep, then runs
//   S_POP, S_POPW and S_CURD per dequeued cell and S_NBR (plus S_NBE when the
//   neighbour is in the grid) per neighbour, then the portal check S_PA, S_PB,
//   S_PC, which may seed a second walk. The walk is paced by the one read port
//   of the distance/visited memories, shared by every neighbour check.
//   One request is in work at a time; req_ch.ready is low meanwhile.
//   After reset the block sweeps every entry of the wall and visited memories
//   and accepts no request meanwhile; register writes are taken.
//   When the receiver stalls, the finished result holds in the output
//   register; the next request may be accepted, and its result waits until
//   the held beat is taken.
// ----------------------------------------------------------------------------
module grid_bfs_distance_map_top (
   input logic clock,
   input logic reset,
   gbfs_req_if.sink   req_ch,
   gbfs_rsp_if.source rsp_ch,
   gbfs_csr_if.sink   csr_ch
);
   import gbfs_pkg::*;

   state_type state_ff, state_in;

   logic                 wall_mem [CELLS];
   logic                 vis_mem  [CELLS];
   logic [DIST_W-1:0]    dist_mem [CELLS];
   logic [XW+YW-1:0]     q_mem    [CELLS];

   logic                 wall_we, vis_we, dist_we, q_we;
   logic [IDX_W-1:0]     wall_wa, vis_wa, dist_wa, rd_addr;
   logic                 wall_wd, vis_wd;
   logic [DIST_W-1:0]    dist_wd;
   logic [IDX_W-1:0]     q_wa, q_ra;
   logic [XW+YW-1:0]     q_wd;
   logic                 wall_q, vis_q;
   logic [DIST_W-1:0]    dist_q;
   logic [XW+YW-1:0]     q_q;

   logic                 pen_ff, pen_in;
   logic [COORD_W-1:0]   pax_ff, pax_in, pay_ff, pay_in, pbx_ff, pbx_in, pby_ff, pby_in;

   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic                 pdone_ff, pdone_in;
   logic [PTR_W-1:0]     rdp_ff, rdp_in, wrp_ff, wrp_in;
   logic [XW-1:0]        cx_ff, cx_in, nx_ff, nx_in;
   logic [YW-1:0]        cy_ff, cy_in, ny_ff, ny_in;
   logic [DIST_W-1:0]    nd_ff, nd_in;
   logic [1:0]           dir_ff, dir_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIST_W:0]      da_ff, da_in;
   logic [COORD_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic                 rb_ff, rb_in;
   logic                 resr_ff, resr_in;
   logic [DIST_W-1:0]    resd_ff, resd_in;
   logic [COUNT_W-1:0]   resc_ff, resc_in;
   logic                 ov_ff, ov_in;
   logic                 oreach_ff, oreach_in;
   logic [DIST_W-1:0]    odist_ff, odist_in;
   logic [COUNT_W-1:0]   ocnt_ff, ocnt_in;

   logic                 req_beat, rsp_free;
   logic                 nb_ok;
   logic [XW-1:0]        nb_x;
   logic [YW-1:0]        nb_y;
   logic                 portal_ok, offer_ok;
   logic [DIST_W:0]      db;
   logic [IDX_W-1:0]     ia, ib;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_free = !ov_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.reachable = oreach_ff;
   assign rsp_ch.distance = odist_ff;
   assign rsp_ch.reached_count = ocnt_ff;

   assign portal_ok = pen_ff && in_grid(pax_ff, pay_ff) && in_grid(pbx_ff, pby_ff);
   assign ia = cell_index(XW'(pax_ff), YW'(pay_ff));
   assign ib = cell_index(XW'(pbx_ff), YW'(pby_ff));
   assign db = vis_q ? {1'b0, dist_q} : '1;
   assign offer_ok = !wall_q && (!vis_q || (dist_q > nd_ff));

   always_comb begin
      nb_ok = 1'b0;
      nb_x  = cx_ff;
      nb_y  = cy_ff;
      case (dir_ff)
         2'd0: begin
            nb_ok = (cx_ff != '0);
            nb_x  = cx_ff - XW'(1);
         end
         2'd1: begin
            nb_ok = (cx_ff != XW'(GRID_W - 1));
            nb_x  = cx_ff + XW'(1);
         end
         2'd2: begin
            nb_ok = (cy_ff != '0);
            nb_y  = cy_ff - YW'(1);
         end
         default: begin
            nb_ok = (cy_ff != YW'(GRID_H - 1));
            nb_y  = cy_ff + YW'(1);
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (wall_we) wall_mem[wall_wa] <= wall_wd;
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      if (q_we) q_mem[q_wa] <= q_wd;
      wall_q <= wall_mem[rd_addr];
      vis_q  <= vis_mem[rd_addr];
      dist_q <= dist_mem[rd_addr];
      q_q    <= q_mem[q_ra];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: if (clr_ff == IDX_W'(CELLS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_beat) begin
               case (req_ch.req_type)
                  REQ_WRITE: state_in = S_WR;
                  REQ_FLOOD: state_in = S_CLR;
                  REQ_READ:  state_in = S_RDA;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_WR:   state_in = S_DONE;
         S_RDA:  state_in = S_RDW;
         S_RDW:  state_in = S_DONE;
         S_CLR:  if (clr_ff == IDX_W'(CELLS - 1)) state_in = S_SEED;
         S_SEED: state_in = in_grid(rx_ff, ry_ff) ? S_POP : S_FIN;
         S_POP: begin
            if (rdp_ff < wrp_ff) state_in = S_POPW;
            else state_in = pdone_ff ? S_FIN : S_PA;
         end
         S_POPW: state_in = S_CURD;
         S_CURD: state_in = S_NBR;
         S_NBR: begin
            if (nb_ok) state_in = S_NBE;
            else if (dir_ff == 2'd3) state_in = S_POP;
         end
         S_NBE:  state_in = (dir_ff == 2'd3) ? S_POP : S_NBR;
         S_PA:   state_in = portal_ok ? S_PB : S_FIN;
         S_PB:   state_in = S_PC;
         S_PC:   state_in = (da_ff != db) ? S_POP : S_FIN;
         S_FIN:  state_in = S_DONE;
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_ch.ready = 1'b0;
      wall_we = 1'b0; wall_wa = '0; wall_wd = 1'b0;
      vis_we  = 1'b0; vis_wa  = '0; vis_wd  = 1'b0;
      dist_we = 1'b0; dist_wa = '0; dist_wd = '0;
      q_we    = 1'b0; q_wa    = '0; q_wd    = '0;
      rd_addr = '0;   q_ra    = rdp_ff[IDX_W-1:0];
      pen_in = pen_ff; pax_in = pax_ff; pay_in = pay_ff;
      pbx_in = pbx_ff; pby_in = pby_ff;
      clr_in = clr_ff; pdone_in = pdone_ff; rdp_in = rdp_ff; wrp_in = wrp_ff;
      cx_in = cx_ff; cy_in = cy_ff; nx_in = nx_ff; ny_in = ny_ff;
      nd_in = nd_ff; dir_in = dir_ff; cnt_in = cnt_ff; da_in = da_ff;
      rx_in = rx_ff; ry_in = ry_ff; rb_in = rb_ff;
      resr_in = resr_ff; resd_in = resd_ff; resc_in = resc_ff;
      ov_in = ov_ff; oreach_in = oreach_ff; odist_in = odist_ff; ocnt_in = ocnt_ff;

      if (ov_ff && rsp_ch.ready) ov_in = 1'b0;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PORTAL_EN: pen_in = csr_ch.data[0];
            CSR_PORTAL_AX: pax_in = csr_ch.data;
            CSR_PORTAL_AY: pay_in = csr_ch.data;
            CSR_PORTAL_BX: pbx_in = csr_ch.data;
            CSR_PORTAL_BY: pby_in = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         S_INIT: begin
            wall_we = 1'b1; wall_wa = clr_ff;
            vis_we  = 1'b1; vis_wa  = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_beat) begin
               rx_in = req_ch.cell_x;
               ry_in = req_ch.cell_y;
               rb_in = req_ch.blocked;
               resr_in = 1'b0; resd_in = '0; resc_in = '0;
               clr_in = '0;
            end
         end
         S_WR: begin
            wall_we = in_grid(rx_ff, ry_ff);
            wall_wa = cell_index(XW'(rx_ff), YW'(ry_ff));
            wall_wd = rb_ff;
         end
         S_RDA: rd_addr = cell_index(XW'(rx_ff), YW'(ry_ff));
         S_RDW: begin
            if (in_grid(rx_ff, ry_ff) && vis_q) begin
               resr_in = 1'b1;
               resd_in = dist_q;
            end
         end
         S_CLR: begin
            vis_we = 1'b1; vis_wa = clr_ff;
            clr_in = clr_ff + IDX_W'(1);
            cnt_in = '0;
         end
         S_SEED: begin
            if (in_grid(rx_ff, ry_ff)) begin
               vis_we = 1'b1; vis_wd = 1'b1;
               vis_wa = cell_index(XW'(rx_ff), YW'(ry_ff));
               dist_we = 1'b1; dist_wa = vis_wa; dist_wd = '0;
               q_we = 1'b1; q_wa = '0; q_wd = {YW'(ry_ff), XW'(rx_ff)};
               rdp_in = '0; wrp_in = PTR_W'(1);
               cnt_in = COUNT_W'(1);
               pdone_in = 1'b0;
            end
         end
         S_POP: if (rdp_ff < wrp_ff) rdp_in = rdp_ff + PTR_W'(1);
         S_POPW: begin
            cx_in = q_q[XW-1:0];
            cy_in = q_q[XW+YW-1:XW];
            rd_addr = cell_index(q_q[XW-1:0], q_q[XW+YW-1:XW]);
         end
         S_CURD: begin
            nd_in  = (dist_q == DIST_MAX) ? DIST_MAX : dist_q + DIST_W'(1);
            dir_in = 2'd0;
         end
         S_NBR: begin
            if (nb_ok) begin
               rd_addr = cell_index(nb_x, nb_y);
               nx_in = nb_x; ny_in = nb_y;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NBE: begin
            dir_in = dir_ff + 2'd1;
            if (offer_ok) begin
               vis_we = 1'b1; vis_wd = 1'b1; vis_wa = cell_index(nx_ff, ny_ff);
               dist_we = 1'b1; dist_wa = vis_wa; dist_wd = nd_ff;
               if (!vis_q) cnt_in = cnt_ff + COUNT_W'(1);
               if (wrp_ff < PTR_W'(CELLS)) begin
                  q_we = 1'b1; q_wa = wrp_ff[IDX_W-1:0]; q_wd = {ny_ff, nx_ff};
                  wrp_in = wrp_ff + PTR_W'(1);
               end
            end
         end
         S_PA: rd_addr = ia;
         S_PB: begin
            da_in = vis_q ? {1'b0, dist_q} : '1;
            rd_addr = ib;
         end
         S_PC: begin
            // seed the farther end with the nearer end's distance
            if (da_ff < db) begin
               vis_we = 1'b1; vis_wd = 1'b1; vis_wa = ib;
               dist_we = 1'b1; dist_wa = ib; dist_wd = da_ff[DIST_W-1:0];
               q_we = 1'b1; q_wa = '0; q_wd = {YW'(pby_ff), XW'(pbx_ff)};
               if (!vis_q) cnt_in = cnt_ff + COUNT_W'(1);
            end else if (db < da_ff) begin
               vis_we = 1'b1; vis_wd = 1'b1; vis_wa = ia;
               dist_we = 1'b1; dist_wa = ia; dist_wd = db[DIST_W-1:0];
               q_we = 1'b1; q_wa = '0; q_wd = {YW'(pay_ff), XW'(pax_ff)};
               if (da_ff[DIST_W]) cnt_in = cnt_ff + COUNT_W'(1);
            end
            rdp_in = '0; wrp_in = PTR_W'(1);
            pdone_in = 1'b1;
         end
         S_FIN: resc_in = cnt_ff;
         S_DONE: begin
            if (rsp_free) begin
               ov_in = 1'b1;
               oreach_in = resr_ff;
               odist_in = resd_ff;
               ocnt_in = resc_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         clr_ff   <= '0;
         pdone_ff <= 1'b0;
         rdp_ff   <= '0;
         wrp_ff   <= '0;
         dir_ff   <= '0;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
         pen_ff   <= 1'b1;
         pax_ff   <= COORD_W'(0);
         pay_ff   <= COORD_W'(14);
         pbx_ff   <= COORD_W'(29);
         pby_ff   <= COORD_W'(14);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pdone_ff <= pdone_in;
         rdp_ff   <= rdp_in;
         wrp_ff   <= wrp_in;
         dir_ff   <= dir_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
         pen_ff   <= pen_in;
         pax_ff   <= pax_in;
         pay_ff   <= pay_in;
         pbx_ff   <= pbx_in;
         pby_ff   <= pby_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; nx_ff <= nx_in; ny_ff <= ny_in;
      nd_ff <= nd_in; da_ff <= da_in;
      rx_ff <= rx_in; ry_ff <= ry_in; rb_ff <= rb_in;
      resr_ff <= resr_in; resd_ff <= resd_in; resc_ff <= resc_in;
      oreach_ff <= oreach_in; odist_ff <= odist_in; ocnt_ff <= ocnt_in;
   end

endmodule

// ===== design/gbfs_checker.sv =====
// ----------------------------------------------------------------------------
// gbfs_checker: port-level checks on the grid distance map
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module gbfs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_reachable,
   input logic [gbfs_pkg::DIST_W-1:0]  rsp_distance,
   input logic [gbfs_pkg::COUNT_W-1:0] rsp_reached_count
);
   import gbfs_pkg::*;

   // a result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_unreached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_distance == '0)
      else $error("distance on unreached cell");

   a_read_or_flood: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reachable |-> rsp_reached_count == '0)
      else $error("read and flood fields both set");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_reached_count) <= CELLS)
      else $error("reached count beyond grid size");

endmodule

bind grid_bfs_distance_map_top gbfs_checker u_gbfs_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_reachable(rsp_ch.reachable),
   .rsp_distance(rsp_ch.distance),
   .rsp_reached_count(rsp_ch.reached_count)
);
